>>> rtl/line_rasterizer_unit_defines.svh
// Assertion macros shared by the line rasteriser checker.
// Every macro samples on clock; only the reset macro runs through reset.
`ifndef LINE_RASTERIZER_UNIT_DEFINES_SVH
`define LINE_RASTERIZER_UNIT_DEFINES_SVH

// Same-cycle implication, off while reset is high.
`define LRU_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lru_checker: implication violated");

// Next-cycle implication, off while reset is high.
`define LRU_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lru_checker: next-cycle implication violated");

// Same-cycle implication that also holds through reset.
`define LRU_ASSERT_ALW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) (ante) |-> (cons)) \
      else $error("lru_checker: reset property violated");

`endif

>>> rtl/lru_pkg.sv
// Shared widths and the command record for the line rasteriser.
// No dependencies; used by every module of the block.
package lru_pkg;

   localparam int COORD_BITS    = 6;
   // Error term spans roughly -2*span .. +2*span, so three bits over a coordinate
   localparam int ERR_BITS      = COORD_BITS + 3;
   localparam int REQ_DATA_BITS = ((4 * COORD_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS = ((2 * COORD_BITS + 7) / 8) * 8;
   // Queue depth must stay a power of two so the pointers wrap on their own
   localparam int QUEUE_DEPTH   = 2;
   localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);

   typedef logic [COORD_BITS-1:0]      coord_type;
   typedef logic signed [ERR_BITS-1:0] err_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      err_type   err;
      err_type   inc_major;
      err_type   inc_minor;
      coord_type steps;
      logic      neg_x;
      logic      neg_y;
      logic      x_major;
   } cmd_type;

endpackage

>>> rtl/lru_front.sv
// Front end: unpacks a line transaction and classifies it (octant, spans, error setup).
// Depends on lru_pkg.
module lru_front
   import lru_pkg::*;
(
   input  logic [REQ_DATA_BITS-1:0] req_data,
   output cmd_type                  cmd
);

   coord_type xs, ys, xe, ye;
   coord_type dx, dy;
   logic      neg_x, neg_y, x_major;
   err_type   dx_e, dy_e;

   always_comb begin
      xs = req_data[COORD_BITS-1:0];
      ys = req_data[2*COORD_BITS-1:COORD_BITS];
      xe = req_data[3*COORD_BITS-1:2*COORD_BITS];
      ye = req_data[4*COORD_BITS-1:3*COORD_BITS];

      neg_x   = (xe < xs);
      neg_y   = (ye < ys);
      dx      = neg_x ? (xs - xe) : (xe - xs);
      dy      = neg_y ? (ys - ye) : (ye - ys);
      x_major = (dx > dy);

      dx_e = signed'({3'b000, dx});
      dy_e = signed'({3'b000, dy});

      cmd.x       = xs;
      cmd.y       = ys;
      cmd.neg_x   = neg_x;
      cmd.neg_y   = neg_y;
      cmd.x_major = x_major;
      if (x_major) begin
         cmd.inc_minor = (dy_e - dx_e) <<< 1;
         cmd.inc_major = dy_e <<< 1;
         cmd.err       = (dy_e <<< 1) - dx_e;
         cmd.steps     = dx;
      end else begin
         cmd.inc_minor = (dx_e - dy_e) <<< 1;
         cmd.inc_major = dx_e <<< 1;
         cmd.err       = (dx_e <<< 1) - dy_e;
         cmd.steps     = dy;
      end
   end

endmodule

>>> rtl/lru_queue.sv
// Short command queue between the front end and the pixel stepper.
// Depends on lru_pkg.
module lru_queue
   import lru_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output cmd_type head_cmd
);

   cmd_type               mem_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]  count_ff, count_in;
   logic                  do_push, do_pop;

   assign full     = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign head_cmd = mem_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> rtl/lru_back.sv
// Back end: steps one queued command pixel by pixel into an output register.
// Depends on lru_pkg.
module lru_back
   import lru_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      cmd_valid,
   input  cmd_type   cmd,
   output logic      cmd_pop,
   output logic      out_valid,
   input  logic      out_ready,
   output coord_type out_x,
   output coord_type out_y,
   output logic      out_last
);

   logic      busy_ff, busy_in;
   coord_type cur_x_ff, cur_x_in;
   coord_type cur_y_ff, cur_y_in;
   err_type   err_ff, err_in;
   err_type   inc_major_ff, inc_major_in;
   err_type   inc_minor_ff, inc_minor_in;
   coord_type steps_ff, steps_in;
   logic      neg_x_ff, neg_x_in;
   logic      neg_y_ff, neg_y_in;
   logic      x_major_ff, x_major_in;

   logic      valid_ff, valid_in;
   coord_type px_ff, py_ff;
   logic      plast_ff;

   logic      out_free, emit, finishing, load, minor;

   assign out_free  = !valid_ff || out_ready;
   assign emit      = busy_ff && out_free;
   assign finishing = emit && (steps_ff == '0);
   // Take the next command in the cycle that sends the last pixel of this one
   assign load      = cmd_valid && (!busy_ff || finishing);
   assign minor     = !err_ff[ERR_BITS-1];
   assign cmd_pop   = load;

   always_comb begin
      busy_in      = busy_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      err_in       = err_ff;
      inc_major_in = inc_major_ff;
      inc_minor_in = inc_minor_ff;
      steps_in     = steps_ff;
      neg_x_in     = neg_x_ff;
      neg_y_in     = neg_y_ff;
      x_major_in   = x_major_ff;

      if (load) begin
         busy_in      = 1'b1;
         cur_x_in     = cmd.x;
         cur_y_in     = cmd.y;
         err_in       = cmd.err;
         inc_major_in = cmd.inc_major;
         inc_minor_in = cmd.inc_minor;
         steps_in     = cmd.steps;
         neg_x_in     = cmd.neg_x;
         neg_y_in     = cmd.neg_y;
         x_major_in   = cmd.x_major;
      end else if (finishing) begin
         busy_in = 1'b0;
      end else if (emit) begin
         err_in   = err_ff + (minor ? inc_minor_ff : inc_major_ff);
         steps_in = steps_ff - 1'b1;
         if (x_major_ff || minor) begin
            cur_x_in = neg_x_ff ? cur_x_ff - 1'b1 : cur_x_ff + 1'b1;
         end
         if (!x_major_ff || minor) begin
            cur_y_in = neg_y_ff ? cur_y_ff - 1'b1 : cur_y_ff + 1'b1;
         end
      end

      valid_in = emit ? 1'b1 : (out_ready ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         valid_ff   <= 1'b0;
         cur_x_ff   <= '0;
         cur_y_ff   <= '0;
         err_ff     <= '0;
         steps_ff   <= '0;
         neg_x_ff   <= 1'b0;
         neg_y_ff   <= 1'b0;
         x_major_ff <= 1'b0;
      end else begin
         busy_ff    <= busy_in;
         valid_ff   <= valid_in;
         cur_x_ff   <= cur_x_in;
         cur_y_ff   <= cur_y_in;
         err_ff     <= err_in;
         steps_ff   <= steps_in;
         neg_x_ff   <= neg_x_in;
         neg_y_ff   <= neg_y_in;
         x_major_ff <= x_major_in;
      end
   end

   always_ff @(posedge clock) begin
      inc_major_ff <= inc_major_in;
      inc_minor_ff <= inc_minor_in;
      if (emit) begin
         px_ff    <= cur_x_ff;
         py_ff    <= cur_y_ff;
         plast_ff <= (steps_ff == '0);
      end
   end

   assign out_valid = valid_ff;
   assign out_x     = px_ff;
   assign out_y     = py_ff;
   assign out_last  = plast_ff;

endmodule

>>> rtl/line_rasterizer_unit.sv
// Bresenham line rasteriser: one line transaction in, 1 + max(|dx|,|dy|) pixels out.
// Path: a line goes through the queue, the stepper state and the output register to rsp_tvalid.
// Throughput: one pixel per cycle from the stepper's error update loop if rsp_tready is high;
// back-to-back lines run without a gap, up to 64 pixels each, behind a 2-entry command queue.
// Reset: synchronous, active high; empties the queue, stops the stepper, drops rsp_tvalid.
module line_rasterizer_unit
   import lru_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,  // x_start, y_start, x_end, y_end
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,  // pixel_x, pixel_y, zero pad
   output logic                     rsp_tlast   // last_pixel
);

   cmd_type   front_cmd, head_cmd;
   logic      q_full, q_empty, q_pop;
   coord_type pix_x, pix_y;

   lru_front u_front (
      .req_data (req_tdata),
      .cmd      (front_cmd)
   );

   lru_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (req_tvalid),
      .push_cmd (front_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .empty    (q_empty),
      .head_cmd (head_cmd)
   );

   lru_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (!q_empty),
      .cmd       (head_cmd),
      .cmd_pop   (q_pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_x     (pix_x),
      .out_y     (pix_y),
      .out_last  (rsp_tlast)
   );

   assign req_tready = !q_full;
   assign rsp_tdata  = RSP_DATA_BITS'({pix_y, pix_x});

endmodule

>>> rtl/lru_checker.sv
// Port-level checker for line_rasterizer_unit, bound to the top level.
// Depends on lru_pkg and line_rasterizer_unit_defines.svh.
`include "line_rasterizer_unit_defines.svh"

module lru_checker
   import lru_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     rsp_tvalid,
   input logic                     rsp_tready,
   input logic [RSP_DATA_BITS-1:0] rsp_tdata,
   input logic                     rsp_tlast
);

   coord_type prev_x_ff, prev_y_ff;
   logic      open_ff;
   logic      rsp_xfer;
   coord_type cur_x, cur_y, diff_x, diff_y;
   logic      near_x, near_y, moved;

   assign rsp_xfer = rsp_tvalid && rsp_tready;
   assign cur_x    = rsp_tdata[COORD_BITS-1:0];
   assign cur_y    = rsp_tdata[2*COORD_BITS-1:COORD_BITS];
   assign diff_x   = cur_x - prev_x_ff;
   assign diff_y   = cur_y - prev_y_ff;
   assign near_x   = (diff_x == '0) || (diff_x == COORD_BITS'(1)) || (diff_x == '1);
   assign near_y   = (diff_y == '0) || (diff_y == COORD_BITS'(1)) || (diff_y == '1);
   assign moved    = (diff_x != '0) || (diff_y != '0);

   // Track the previous pixel while a line is still open
   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= 1'b0;
      end else if (rsp_xfer) begin
         open_ff <= !rsp_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_xfer) begin
         prev_x_ff <= cur_x;
         prev_y_ff <= cur_y;
      end
   end

   `LRU_ASSERT_NXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
   `LRU_ASSERT_IMP(a_pixel_adjacent, rsp_xfer && open_ff, near_x && near_y)
   `LRU_ASSERT_IMP(a_pixel_moves, rsp_xfer && open_ff, moved)
   `LRU_ASSERT_ALW(a_reset_quiet, $past(reset), !rsp_tvalid)

endmodule

bind line_rasterizer_unit lru_checker u_checker (.*);

>>> verif/line_rasterizer_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for line_rasterizer_unit: line transactions in, pixel transactions out,
// each compared with an in-bench Bresenham model or typed-in pixels. Depends on lru_pkg, RTL only.
module line_rasterizer_unit_tb;
   import lru_pkg::*;

   localparam int RANDOM_PER_PHASE = 107;
   localparam int HOLD_CYCLES      = 400;
   localparam int STALL_LIMIT      = 2000;
   localparam int TAIL_CYCLES      = 16;

   typedef struct packed {
      coord_type x;
      coord_type y;
      logic      last;
   } pixel_type;

   // n_fixed = 0: pixels come from the model; otherwise they are typed in below
   typedef struct {
      coord_type xs;
      coord_type ys;
      coord_type xe;
      coord_type ye;
      int        n_fixed;
      coord_type fx0;
      coord_type fy0;
      coord_type fx1;
      coord_type fy1;
   } line_cmd_type;

   logic                     clock      = 1'b0;
   logic                     reset      = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata  = '0;  // x_start, y_start, x_end, y_end
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;        // pixel_x, pixel_y, zero pad
   logic                     rsp_tlast;        // last_pixel

   line_cmd_type lines_in_flight[$];
   pixel_type    expected_pixels[$];
   int           fault_count      = 0;
   int           stall_cycles     = 0;
   int           sender_idle_pct  = 0;
   int           rsp_stall_pct    = 0;
   int           holdoff_requests = 0;
   int           holdoffs_served  = 0;
   int           hold_left        = 0;

   // model state
   coord_type          pos_x, pos_y;
   err_type            err_acc;
   logic [COORD_BITS:0] steps_togo;
   logic               neg_x, neg_y, along_x;

   line_cmd_type directed_lines [23] = '{
      '{ 0,  0,  0,  0, 1,  0,  0,  0,  0},   // single point straight after reset
      '{63, 63, 63, 63, 1, 63, 63,  0,  0},
      '{63,  0, 63,  0, 1, 63,  0,  0,  0},
      '{ 5,  5,  6,  6, 2,  5,  5,  6,  6},
      '{63,  0, 62,  1, 2, 63,  0, 62,  1},
      '{ 0, 63,  1, 63, 2,  0, 63,  1, 63},
      '{ 0,  0, 63,  0, 0,  0,  0,  0,  0},   // full-width horizontal, both ways
      '{63, 63,  0, 63, 0,  0,  0,  0,  0},
      '{ 0,  0,  0, 63, 0,  0,  0,  0,  0},
      '{ 0, 63,  0,  0, 0,  0,  0,  0,  0},
      '{ 0,  0, 63, 63, 0,  0,  0,  0,  0},   // equal spans take the y-major branch
      '{63,  0,  0, 63, 0,  0,  0,  0,  0},
      '{10, 20, 50, 30, 0,  0,  0,  0,  0},   // one line per octant
      '{50, 30, 10, 20, 0,  0,  0,  0,  0},
      '{10, 30, 50, 20, 0,  0,  0,  0,  0},
      '{50, 20, 10, 30, 0,  0,  0,  0,  0},
      '{20, 10, 30, 50, 0,  0,  0,  0,  0},
      '{30, 50, 20, 10, 0,  0,  0,  0,  0},
      '{20, 50, 30, 10, 0,  0,  0,  0,  0},
      '{30, 10, 20, 50, 0,  0,  0,  0,  0},
      '{ 0,  0, 63, 62, 0,  0,  0,  0,  0},
      '{ 1,  0,  0, 63, 0,  0,  0,  0,  0},
      '{42, 21, 21, 42, 0,  0,  0,  0,  0}
   };

   line_rasterizer_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #4 clock = ~clock;

   function automatic coord_type step_coord(input coord_type v, input logic down);
      return down ? v - 1'b1 : v + 1'b1;
   endfunction

   // Walk the line and queue every pixel it plots, start point first
   function automatic void rasterise_line(input line_cmd_type c);
      err_type   inc_major, inc_minor;
      coord_type span_x, span_y;
      logic      minor_step;
      pixel_type pix;
      neg_x   = c.xe < c.xs;
      neg_y   = c.ye < c.ys;
      span_x  = neg_x ? c.xs - c.xe : c.xe - c.xs;
      span_y  = neg_y ? c.ys - c.ye : c.ye - c.ys;
      along_x = span_x > span_y;
      pos_x   = c.xs;
      pos_y   = c.ys;
      if (along_x) begin
         inc_minor  = err_type'(2 * (int'(span_y) - int'(span_x)));
         inc_major  = err_type'(2 * int'(span_y));
         err_acc    = err_type'(2 * int'(span_y) - int'(span_x));
         steps_togo = {1'b0, span_x};
      end else begin
         inc_minor  = err_type'(2 * (int'(span_x) - int'(span_y)));
         inc_major  = err_type'(2 * int'(span_x));
         err_acc    = err_type'(2 * int'(span_x) - int'(span_y));
         steps_togo = {1'b0, span_y};
      end
      pix.x = pos_x;
      pix.y = pos_y;
      pix.last = (steps_togo == 0);
      expected_pixels.push_back(pix);
      while (steps_togo != 0) begin
         minor_step = !err_acc[ERR_BITS-1];
         err_acc = err_acc + (minor_step ? inc_minor : inc_major);
         if (along_x) begin
            if (minor_step) pos_y = step_coord(pos_y, neg_y);
            pos_x = step_coord(pos_x, neg_x);
         end else begin
            if (minor_step) pos_x = step_coord(pos_x, neg_x);
            pos_y = step_coord(pos_y, neg_y);
         end
         steps_togo = steps_togo - 1'b1;
         pix.x = pos_x;
         pix.y = pos_y;
         pix.last = (steps_togo == 0);
         expected_pixels.push_back(pix);
      end
   endfunction

   // Mostly uniform endpoints, plus short lines, axis-aligned lines, points and diagonals
   function automatic line_cmd_type random_line();
      line_cmd_type c;
      int           kind, t, reach_x, reach_y, d;
      logic         dn_x, dn_y;
      c = '{default: 0};
      c.xs = coord_type'($urandom);
      c.ys = coord_type'($urandom);
      c.xe = coord_type'($urandom);
      c.ye = coord_type'($urandom);
      kind = $urandom_range(9);
      if (kind >= 5 && kind <= 7) begin
         t = int'(c.xs) + $urandom_range(6) - 3;
         c.xe = coord_type'((t < 0) ? 0 : (t > 63) ? 63 : t);
         t = int'(c.ys) + $urandom_range(6) - 3;
         c.ye = coord_type'((t < 0) ? 0 : (t > 63) ? 63 : t);
      end else if (kind == 8) begin
         case ($urandom_range(2))
            0: c.xe = c.xs;
            1: c.ye = c.ys;
            default: begin
               c.xe = c.xs;
               c.ye = c.ys;
            end
         endcase
      end else if (kind == 9) begin
         dn_x = 1'($urandom_range(1));
         dn_y = 1'($urandom_range(1));
         reach_x = dn_x ? int'(c.xs) : 63 - int'(c.xs);
         reach_y = dn_y ? int'(c.ys) : 63 - int'(c.ys);
         d = $urandom_range((reach_x < reach_y) ? reach_x : reach_y);
         c.xe = coord_type'(dn_x ? int'(c.xs) - d : int'(c.xs) + d);
         c.ye = coord_type'(dn_y ? int'(c.ys) - d : int'(c.ys) + d);
      end
      return c;
   endfunction

   task automatic send_line(input line_cmd_type c);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      lines_in_flight.push_back(c);
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_BITS'({c.ye, c.xe, c.ys, c.xs});
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      while (lines_in_flight.size() != 0 || expected_pixels.size() != 0) @(posedge clock);
   endtask

   // Receiver: random back-pressure, plus a long hold-off when the sender asks for one
   always @(posedge clock) begin
      if (hold_left == 0 && holdoffs_served != holdoff_requests) begin
         holdoffs_served = holdoff_requests;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
         hold_left = hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Both channels in one process, so a line is always predicted before its pixels are checked
   always @(posedge clock) begin : monitor
      line_cmd_type ln;
      pixel_type    want, fixed_pix;
      coord_type    got_x, got_y;
      int k;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            if (lines_in_flight.size() == 0) begin
               $error("line transaction accepted with nothing offered");
               fault_count++;
            end else begin
               ln = lines_in_flight.pop_front();
               if (ln.n_fixed == 0) begin
                  rasterise_line(ln);
               end else begin
                  for (k = 0; k < ln.n_fixed; k++) begin
                     fixed_pix.x    = (k == 0) ? ln.fx0 : ln.fx1;
                     fixed_pix.y    = (k == 0) ? ln.fy0 : ln.fy1;
                     fixed_pix.last = (k == ln.n_fixed - 1);
                     expected_pixels.push_back(fixed_pix);
                  end
               end
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            got_x = rsp_tdata[COORD_BITS-1:0];
            got_y = rsp_tdata[2*COORD_BITS-1:COORD_BITS];
            if (expected_pixels.size() == 0) begin
               $error("unexpected pixel transaction: x %0d y %0d last %0b",
                      got_x, got_y, rsp_tlast);
               fault_count++;
            end else begin
               want = expected_pixels.pop_front();
               if (got_x !== want.x) begin
                  $error("pixel_x: expected %0d, got %0d", want.x, got_x);
                  fault_count++;
               end
               if (got_y !== want.y) begin
                  $error("pixel_y: expected %0d, got %0d", want.y, got_y);
                  fault_count++;
               end
               if (rsp_tlast !== want.last) begin
                  $error("last_pixel: expected %0b, got %0b", want.last, rsp_tlast);
                  fault_count++;
               end
            end
         end
      end
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles = stall_cycles + 1;
         if (stall_cycles == STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   initial begin : stimulus
      line_cmd_type c;
      int phase, k;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_lines[i]) send_line(directed_lines[i]);
      for (phase = 0; phase < 4; phase++) begin
         // pause the sender until every pixel so far has come back
         wait_for_drain();
         case (phase)
            0: begin
               sender_idle_pct = 0;
               rsp_stall_pct   = 0;
               // hold the receiver off while lines keep coming, to fill the queue
               holdoff_requests++;
            end
            1: begin
               sender_idle_pct = 56;
               rsp_stall_pct   = 0;
            end
            2: begin
               sender_idle_pct = 0;
               rsp_stall_pct   = 56;
            end
            default: begin
               sender_idle_pct = 27;
               rsp_stall_pct   = 27;
            end
         endcase
         for (k = 0; k < RANDOM_PER_PHASE; k++) begin
            c = random_line();
            send_line(c);
         end
      end
      wait_for_drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fault_count == 0 && expected_pixels.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
